@@ rtl/haversine_distance_to_reference_macros.svh @@
// Assertion macros for the haversine distance block.
// Needs clk and arst_n in the scope that expands them.
`ifndef HAVERSINE_DISTANCE_TO_REFERENCE_MACROS_SVH
`define HAVERSINE_DISTANCE_TO_REFERENCE_MACROS_SVH

`define HDR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define HDR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/hdr_pkg.sv @@
// Types, constants and step functions for the haversine distance block.
// No dependencies.
package hdr_pkg;

	typedef struct packed {
		logic signed [23:0] point_latitude;
		logic signed [23:0] point_longitude;
		logic signed [31:0] point_depth;
		logic               in_last;
	} point_t;

	typedef struct packed {
		logic [30:0] distance_km;
		logic        out_last;
	} dist_t;

	typedef enum logic [1:0] {
		CFG_REF_LAT = 2'b00,
		CFG_REF_LON = 2'b01,
		CFG_REF_DEP = 2'b10
	} cfg_reg_t;

	typedef logic signed [32:0] q30_t;

	typedef struct packed {
		q30_t x;
		q30_t y;
		q30_t z;
		logic neg;
	} rot_t;

	typedef struct packed {
		logic [63:0] v;
		logic [63:0] r;
	} sq_t;

	localparam logic signed [34:0] Q30_PI     = 35'sd3373259426;
	localparam logic signed [34:0] Q30_TWO_PI = 35'sd6746518852;
	localparam logic signed [34:0] Q30_HPI    = 35'sd1686629713;
	localparam q30_t               Q30_GAIN   = 33'sd652032874;
	localparam logic [30:0]        Q30_ONE    = 31'd1073741824;
	localparam logic [28:0]        R_Q16      = 29'd417530446;
	localparam logic [61:0]        ROUND_Q30  = 62'd536870912;
	localparam logic [30:0]        DIST_MAX   = 31'h7FFFFFFF;

	localparam int ROT_N = 30;
	localparam int SQ1_N = 31;
	localparam int VEC_N = 30;
	localparam int SQ2_N = 32;

	// global stage indexes
	localparam int I_ROT = 1;
	localparam int I_M1  = I_ROT + ROT_N + 1;
	localparam int I_M2  = I_M1 + 1;
	localparam int I_SQ1 = I_M2 + 1;
	localparam int I_VEC = I_SQ1 + SQ1_N + 1;
	localparam int I_P1  = I_VEC + VEC_N + 1;
	localparam int I_P2  = I_P1 + 1;
	localparam int I_SQ2 = I_P2 + 1;
	localparam int I_OUT = I_SQ2 + SQ2_N + 1;
	localparam int STG_N = I_OUT + 1;

	function automatic q30_t atan_step(input int unsigned i);
		q30_t a;
		case (i)
			0:  a = 33'sd843314857;
			1:  a = 33'sd497837829;
			2:  a = 33'sd263043837;
			3:  a = 33'sd133525159;
			4:  a = 33'sd67021687;
			5:  a = 33'sd33543516;
			6:  a = 33'sd16775851;
			7:  a = 33'sd8388437;
			8:  a = 33'sd4194283;
			9:  a = 33'sd2097149;
			10: a = 33'sd1048576;
			default: a = 33'sd1 <<< (30 - i);
		endcase
		return a;
	endfunction

	// range reduce to [-pi, pi], fold to [-pi/2, pi/2]
	function automatic rot_t reduce(input q30_t t);
		logic signed [34:0] w;
		rot_t r;
		w = 35'(t);
		r.neg = 1'b0;
		if (w > Q30_PI) begin
			w = w - Q30_TWO_PI;
		end else if (w < -Q30_PI) begin
			w = w + Q30_TWO_PI;
		end
		if (w > Q30_HPI) begin
			w = Q30_PI - w;
			r.neg = 1'b1;
		end else if (w < -Q30_HPI) begin
			w = -Q30_PI - w;
			r.neg = 1'b1;
		end
		r.x = Q30_GAIN;
		r.y = '0;
		r.z = w[32:0];
		return r;
	endfunction

	function automatic rot_t rot_step(input rot_t r, input int unsigned k);
		q30_t x;
		q30_t y;
		q30_t dx;
		q30_t dy;
		q30_t a;
		rot_t o;
		x  = r.x;
		y  = r.y;
		dx = y >>> k;
		dy = x >>> k;
		a  = atan_step(k);
		o  = r;
		if (!r.z[32]) begin
			o.x = x - dx;
			o.y = y + dy;
			o.z = r.z - a;
		end else begin
			o.x = x + dx;
			o.y = y - dy;
			o.z = r.z + a;
		end
		return o;
	endfunction

	function automatic rot_t vec_step(input rot_t r, input int unsigned k);
		q30_t x;
		q30_t y;
		q30_t dx;
		q30_t dy;
		q30_t a;
		rot_t o;
		x  = r.x;
		y  = r.y;
		dx = y >>> k;
		dy = x >>> k;
		a  = atan_step(k);
		o  = r;
		if (!y[32] && (y != '0)) begin
			o.x = x + dx;
			o.y = y - dy;
			o.z = r.z + a;
		end else begin
			o.x = x - dx;
			o.y = y + dy;
			o.z = r.z - a;
		end
		return o;
	endfunction

	// one result bit of a floor square root, bit weight 4^k
	function automatic sq_t sq_step(input sq_t s, input int unsigned k);
		logic [63:0] bitw;
		logic [63:0] trial;
		sq_t o;
		bitw  = 64'd1 << (2 * k);
		trial = s.r + bitw;
		if (s.v >= trial) begin
			o.v = s.v - trial;
			o.r = (s.r >> 1) + bitw;
		end else begin
			o.v = s.v;
			o.r = s.r >> 1;
		end
		return o;
	endfunction

endpackage

@@ rtl/haversine_distance_to_reference.sv @@
// Haversine distance from a stream of locations to a configured reference location.
// Depends on hdr_pkg and haversine_distance_to_reference_macros.svh.
//
// Use:
//   point channel (point_valid / point_stall / point) carries one location per beat.
//   dist channel (dist_valid / dist_stall / distance) returns one distance per location,
//   in order, with the last flag copied through.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the reference
//   latitude, longitude and depth; cfg_ready is always high, unknown indexes are dropped.
//   Write configuration only while no location is in flight.
// Timing:
//   A fully pipelined datapath of 133 register stages: four rotation CORDICs, the
//   haversine products, two square roots, a vectoring CORDIC, the radius product
//   and a final square root. One location per cycle while dist is not stalled.
// Reset clears the reference registers to zero and empties the pipeline.
// While a valid distance is stalled the whole pipeline holds and point_stall is raised.
`include "haversine_distance_to_reference_macros.svh"

module haversine_distance_to_reference (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                point_valid,
	output logic                point_stall,
	input  hdr_pkg::point_t     point,
	output logic                dist_valid,
	input  logic                dist_stall,
	output hdr_pkg::dist_t      distance,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	logic signed [23:0] ref_lat_q;
	logic signed [23:0] ref_lon_q;
	logic signed [31:0] ref_dep_q;

	logic [hdr_pkg::STG_N-1:0] vld_s;
	logic [hdr_pkg::I_OUT-1:0] last_s;
	logic signed [32:0]        dd_s  [0:hdr_pkg::I_P1-1];
	logic                      sat_s [hdr_pkg::I_P1:hdr_pkg::I_OUT-1];
	logic                      en;

	hdr_pkg::q30_t t_s0 [0:3];
	hdr_pkg::rot_t rot_s [0:hdr_pkg::ROT_N][0:3];
	hdr_pkg::q30_t hh_s32;
	hdr_pkg::q30_t cc_s32;
	hdr_pkg::q30_t ll_s32;
	hdr_pkg::q30_t hh_s33;
	hdr_pkg::q30_t q_s33;
	hdr_pkg::sq_t  sq1_s [0:hdr_pkg::SQ1_N][0:1];
	hdr_pkg::rot_t vec_s [0:hdr_pkg::VEC_N];
	logic [61:0]   prod_s97;
	logic [30:0]   mag_s97;
	logic [63:0]   surf2_s98;
	logic [61:0]   mag2_s98;
	hdr_pkg::sq_t  sq2_s [0:hdr_pkg::SQ2_N];
	hdr_pkg::dist_t out_s132;

	assign en          = !(vld_s[hdr_pkg::STG_N-1] && dist_stall);
	assign point_stall = !en;
	assign dist_valid  = vld_s[hdr_pkg::STG_N-1];
	assign distance    = out_s132;
	assign cfg_ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_lat_q <= '0;
			ref_lon_q <= '0;
			ref_dep_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				hdr_pkg::CFG_REF_LAT: ref_lat_q <= cfg_data[23:0];
				hdr_pkg::CFG_REF_LON: ref_lon_q <= cfg_data[23:0];
				hdr_pkg::CFG_REF_DEP: ref_dep_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[hdr_pkg::STG_N-2:0], point_valid};
		end
	end

	// input stage: Q30 angles, half differences, depth difference
	always_ff @(posedge clk) begin
		if (en) begin
			t_s0[0] <= {ref_lat_q, 9'd0};
			t_s0[1] <= {point.point_latitude, 9'd0};
			t_s0[2] <= {25'({ref_lat_q[23], ref_lat_q} -
				{point.point_latitude[23], point.point_latitude}), 8'd0};
			t_s0[3] <= {25'({ref_lon_q[23], ref_lon_q} -
				{point.point_longitude[23], point.point_longitude}), 8'd0};
			dd_s[0] <= 33'({ref_dep_q[31], ref_dep_q} -
				{point.point_depth[31], point.point_depth});
			last_s  <= {last_s[hdr_pkg::I_OUT-2:0], point.in_last};
		end
	end

	for (genvar i = 1; i < hdr_pkg::I_P1; i++) begin : g_dd
		always_ff @(posedge clk) begin
			if (en) begin
				dd_s[i] <= dd_s[i-1];
			end
		end
	end

	// rotation CORDIC lanes: cos lat1, cos lat2, sin dlat/2, sin dlon/2
	for (genvar l = 0; l < 4; l++) begin : g_lane
		always_ff @(posedge clk) begin
			if (en) begin
				rot_s[0][l] <= hdr_pkg::reduce(t_s0[l]);
			end
		end
		for (genvar k = 0; k < hdr_pkg::ROT_N; k++) begin : g_rot
			always_ff @(posedge clk) begin
				if (en) begin
					rot_s[k+1][l] <= hdr_pkg::rot_step(rot_s[k][l], k);
				end
			end
		end
	end

	hdr_pkg::q30_t      c1;
	hdr_pkg::q30_t      c2;
	hdr_pkg::q30_t      sh;
	hdr_pkg::q30_t      sl;
	logic signed [65:0] p_hh;
	logic signed [65:0] p_cc;
	logic signed [65:0] p_ll;
	logic signed [65:0] p_q;
	logic signed [33:0] a_sum;
	logic [30:0]        a_cl;
	logic [30:0]        b_cl;

	always_comb begin
		c1   = rot_s[hdr_pkg::ROT_N][0].neg ? -rot_s[hdr_pkg::ROT_N][0].x
			: rot_s[hdr_pkg::ROT_N][0].x;
		c2   = rot_s[hdr_pkg::ROT_N][1].neg ? -rot_s[hdr_pkg::ROT_N][1].x
			: rot_s[hdr_pkg::ROT_N][1].x;
		sh   = rot_s[hdr_pkg::ROT_N][2].y;
		sl   = rot_s[hdr_pkg::ROT_N][3].y;
		p_hh = 66'(sh) * 66'(sh);
		p_cc = 66'(c1) * 66'(c2);
		p_ll = 66'(sl) * 66'(sl);
		p_q  = 66'(cc_s32) * 66'(ll_s32);
		a_sum = 34'(hh_s33) + 34'(q_s33);
		if (a_sum < 34'sd0) begin
			a_cl = '0;
		end else if (a_sum > 34'(hdr_pkg::Q30_ONE)) begin
			a_cl = hdr_pkg::Q30_ONE;
		end else begin
			a_cl = a_sum[30:0];
		end
		b_cl = hdr_pkg::Q30_ONE - a_cl;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hh_s32 <= p_hh[62:30];
			cc_s32 <= p_cc[62:30];
			ll_s32 <= p_ll[62:30];
			hh_s33 <= hh_s32;
			q_s33  <= p_q[62:30];
			sq1_s[0][0] <= '{v: {3'd0, a_cl, 30'd0}, r: 64'd0};
			sq1_s[0][1] <= '{v: {3'd0, b_cl, 30'd0}, r: 64'd0};
		end
	end

	for (genvar j = 0; j < hdr_pkg::SQ1_N; j++) begin : g_sq1
		for (genvar l = 0; l < 2; l++) begin : g_sq1_lane
			always_ff @(posedge clk) begin
				if (en) begin
					sq1_s[j+1][l] <= hdr_pkg::sq_step(sq1_s[j][l], hdr_pkg::SQ1_N - 1 - j);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s[0].x   <= {2'b00, sq1_s[hdr_pkg::SQ1_N][1].r[30:0]};
			vec_s[0].y   <= {2'b00, sq1_s[hdr_pkg::SQ1_N][0].r[30:0]};
			vec_s[0].z   <= '0;
			vec_s[0].neg <= 1'b0;
		end
	end

	for (genvar k = 0; k < hdr_pkg::VEC_N; k++) begin : g_vec
		always_ff @(posedge clk) begin
			if (en) begin
				vec_s[k+1] <= hdr_pkg::vec_step(vec_s[k], k);
			end
		end
	end

	logic [32:0]        th;
	logic signed [32:0] dd_last;
	logic [32:0]        mag;
	logic [31:0]        surf;

	always_comb begin
		th      = vec_s[hdr_pkg::VEC_N].z[32] ? 33'd0
			: {vec_s[hdr_pkg::VEC_N].z[31:0], 1'b0};
		dd_last = dd_s[hdr_pkg::I_P1-1];
		mag     = dd_last[32] ? 33'(-dd_last) : 33'(dd_last);
		surf    = prod_s97[61:30];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s97  <= 62'(th) * 62'(hdr_pkg::R_Q16) + hdr_pkg::ROUND_Q30;
			mag_s97   <= mag[30:0];
			sat_s[hdr_pkg::I_P1] <= (mag > 33'(hdr_pkg::DIST_MAX));
			surf2_s98 <= 64'(surf) * 64'(surf);
			mag2_s98  <= 62'(mag_s97) * 62'(mag_s97);
			sq2_s[0]  <= '{v: surf2_s98 + 64'(mag2_s98), r: 64'd0};
		end
	end

	for (genvar i = hdr_pkg::I_P1 + 1; i < hdr_pkg::I_OUT; i++) begin : g_sat
		always_ff @(posedge clk) begin
			if (en) begin
				sat_s[i] <= sat_s[i-1];
			end
		end
	end

	for (genvar j = 0; j < hdr_pkg::SQ2_N; j++) begin : g_sq2
		always_ff @(posedge clk) begin
			if (en) begin
				sq2_s[j+1] <= hdr_pkg::sq_step(sq2_s[j], hdr_pkg::SQ2_N - 1 - j);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sat_s[hdr_pkg::I_OUT-1] ||
				(sq2_s[hdr_pkg::SQ2_N].r[31:0] > 32'(hdr_pkg::DIST_MAX))) begin
				out_s132.distance_km <= hdr_pkg::DIST_MAX;
			end else begin
				out_s132.distance_km <= sq2_s[hdr_pkg::SQ2_N].r[30:0];
			end
			out_s132.out_last <= last_s[hdr_pkg::I_OUT-1];
		end
	end

	`HDR_ASSERT_NEXT(a_hold_on_stall, dist_valid && dist_stall, $stable(vld_s), "pipeline moved under stall")
	`HDR_ASSERT_NEXT(a_enter, point_valid && !point_stall, vld_s[0], "accepted beat lost at entry")
	`HDR_ASSERT_SAME(a_roots, vld_s[hdr_pkg::I_VEC-1], (sq1_s[hdr_pkg::SQ1_N][0].r != 64'd0) || (sq1_s[hdr_pkg::SQ1_N][1].r != 64'd0), "both haversine roots zero")

endmodule
